// File: hdl/secs_pkg.sv
// shared type and arithmetic helpers for the sphere constrained euler step unit
// no dependencies
package secs_pkg;

  localparam int unsigned SqSteps  = 32;  // result bits of the length square root
  localparam int unsigned DivSteps = 25;  // quotient bits of the normal division

  // per-particle data that travels beside the square root and divider stages
  typedef struct packed {
    logic [2:0][31:0] vel;   // updated velocity, signed q8.24
    logic [2:0][31:0] mag;   // magnitude of the moved position
    logic [2:0]       neg;   // sign of the moved position
    logic             zero;  // length was zero
    logic             last;
  } side_t;

  // round to nearest, ties toward +inf, then drop 24 fraction bits
  function automatic logic signed [63:0] rnd24(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd8388608;
    return t >>> 24;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// File: hdl/sphere_constrained_euler_step_unit.sv
// sphere constrained semi-implicit euler step, fully pipelined
// depends on secs_pkg
//
// one particle per cycle sustained while the output is not stalled; depth is
// set by the 32-step length square root and the 25-step normal divider, one
// result bit per stage. a stall at the output holds every stage. reset clears
// the valid bits and loads time_step with 167772.
module sphere_constrained_euler_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i,      // time_step, unsigned q0.24
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position_x/y/z, velocity_x/y/z, force_x/y/z
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tlast,    // final_particle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_position_x/y/z, new_velocity_x/y/z
  output logic [191:0] m_axis_tdata,
  output logic         m_axis_tuser,    // degenerate_origin
  output logic         m_axis_tlast     // frame_end
);
  import secs_pkg::*;

  logic        en;
  logic [23:0] dt_q;
  logic signed [24:0] dt_s;

  assign cfg_ready_o   = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign dt_s          = $signed({1'b0, dt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 24'd167772;
    end else if (cfg_valid_i) begin
      dt_q <= cfg_data_i;
    end
  end

  // stage a: force times dt
  logic             a_vld_q;
  logic [2:0][56:0] a_fp_q;
  logic [2:0][31:0] a_vin_q, a_pin_q;
  logic             a_last_q;
  // stage b: updated velocity
  logic             b_vld_q;
  logic [2:0][31:0] b_v_q, b_pin_q;
  logic             b_last_q;
  // stage c: velocity times dt
  logic             c_vld_q;
  logic [2:0][56:0] c_vp_q;
  logic [2:0][31:0] c_v_q, c_pin_q;
  logic             c_last_q;
  // stage d: moved position
  logic             d_vld_q;
  logic [2:0][31:0] d_p_q, d_v_q;
  logic             d_last_q;
  // stage e: squares
  logic             e_vld_q;
  logic [2:0][63:0] e_sq_q;
  side_t            e_side_q;

  logic [2:0][31:0] d_mag;
  logic [2:0]       d_neg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_neg[i] = d_p_q[i][31];
      d_mag[i] = d_neg[i] ? 32'(-d_p_q[i]) : d_p_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_fp_q[i]  <= 57'($signed(s_axis_tdata[(6+i)*32 +: 32]) * dt_s);
        a_pin_q[i] <= s_axis_tdata[i*32 +: 32];
        a_vin_q[i] <= s_axis_tdata[(3+i)*32 +: 32];

        b_v_q[i]   <= sat32(64'($signed(a_vin_q[i]))
                            + rnd24(64'($signed(a_fp_q[i]))));
        b_pin_q[i] <= a_pin_q[i];

        c_vp_q[i]  <= 57'($signed(b_v_q[i]) * dt_s);
        c_v_q[i]   <= b_v_q[i];
        c_pin_q[i] <= b_pin_q[i];

        d_p_q[i]   <= sat32(64'($signed(c_pin_q[i]))
                            + rnd24(64'($signed(c_vp_q[i]))));
        d_v_q[i]   <= c_v_q[i];

        e_sq_q[i]  <= d_mag[i] * d_mag[i];
      end
      a_last_q      <= s_axis_tlast;
      b_last_q      <= a_last_q;
      c_last_q      <= b_last_q;
      d_last_q      <= c_last_q;
      e_side_q.vel  <= d_v_q;
      e_side_q.mag  <= d_mag;
      e_side_q.neg  <= d_neg;
      e_side_q.zero <= 1'b0;
      e_side_q.last <= d_last_q;
    end
  end

  // length square root, one result bit per stage, remainder kept as x - root^2
  logic [SqSteps:0]        sq_vld_q;
  logic [65:0]             sq_rem_q  [SqSteps+1];
  logic [31:0]             sq_root_q [SqSteps+1];
  side_t                   sq_side_q [SqSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      sq_vld_q <= {sq_vld_q[SqSteps-1:0], e_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= 66'(e_sq_q[0]) + 66'(e_sq_q[1]) + 66'(e_sq_q[2]);
      sq_root_q[0] <= '0;
      sq_side_q[0] <= e_side_q;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam int unsigned B = SqSteps - 1 - k;
    logic [65:0] test;
    logic        ge;
    assign test = (66'(sq_root_q[k]) << (B + 1)) + (66'd1 << (2 * B));
    assign ge   = sq_rem_q[k] >= test;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k+1]  <= ge ? sq_rem_q[k] - test : sq_rem_q[k];
        sq_root_q[k+1] <= ge ? (sq_root_q[k] | (32'd1 << B)) : sq_root_q[k];
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // normal division: (mag * 2^24 + len / 2) / len, one quotient bit per stage
  logic [DivSteps:0]       dv_vld_q;
  logic [2:0][31:0]        dv_rem_q  [DivSteps+1];
  logic [2:0][24:0]        dv_nq_q   [DivSteps+1];
  logic [31:0]             dv_len_q  [DivSteps+1];
  side_t                   dv_side_q [DivSteps+1];

  logic [2:0][56:0] num;
  logic [31:0]      len;
  side_t            dv_side_d;
  assign len = sq_root_q[SqSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_side_q[SqSteps].mag[i], 24'd0} + 57'(len >> 1);
    end
    dv_side_d      = sq_side_q[SqSteps];
    dv_side_d.zero = (len == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[DivSteps-1:0], sq_vld_q[SqSteps]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= num[i][56:25];
        dv_nq_q[0][i]  <= num[i][24:0];
      end
      dv_len_q[0]  <= len;
      dv_side_q[0] <= dv_side_d;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [2:0][32:0] t;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dv_rem_q[k][i], dv_nq_q[k][i][DivSteps-1]};
        ge[i] = t[i] >= {1'b0, dv_len_q[k]};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k+1][i] <= ge[i] ? 32'(t[i] - {1'b0, dv_len_q[k]}) : t[i][31:0];
          dv_nq_q[k+1][i]  <= {dv_nq_q[k][i][DivSteps-2:0], ge[i]};
        end
        dv_len_q[k+1]  <= dv_len_q[k];
        dv_side_q[k+1] <= dv_side_q[k];
      end
    end
  end

  // tail: signed normal, radial dot product, removal, output register
  logic             n_vld_q, m_vld_q, r_vld_q, q_vld_q;
  logic [2:0][25:0] n_n_q, m_n_q, r_n_q;
  logic [2:0][31:0] n_v_q, m_v_q, r_v_q, q_v_q;
  logic [2:0][57:0] m_pr_q;
  logic signed [35:0] r_r_q;
  logic [2:0][61:0] q_rn_q;
  logic [1:0]       n_fl_q, m_fl_q, r_fl_q, q_fl_q;  // {zero, last}
  logic signed [59:0] acc;
  logic [2:0][31:0] o_v;
  // normal carried to the last tail stage
  logic [2:0][25:0] q_nn_q;

  assign acc = 60'($signed(m_pr_q[0])) + 60'($signed(m_pr_q[1]))
             + 60'($signed(m_pr_q[2]));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_v[i] = sat32(64'($signed(q_v_q[i])) - rnd24(64'($signed(q_rn_q[i]))));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q       <= 1'b0;
      m_vld_q       <= 1'b0;
      r_vld_q       <= 1'b0;
      q_vld_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      n_vld_q       <= dv_vld_q[DivSteps];
      m_vld_q       <= n_vld_q;
      r_vld_q       <= m_vld_q;
      q_vld_q       <= r_vld_q;
      m_axis_tvalid <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_n_q[i]  <= dv_side_q[DivSteps].neg[i] ? 26'(-{1'b0, dv_nq_q[DivSteps][i]})
                                                : {1'b0, dv_nq_q[DivSteps][i]};
        n_v_q[i]  <= dv_side_q[DivSteps].vel[i];
        m_pr_q[i] <= 58'($signed(n_v_q[i]) * $signed(n_n_q[i]));
        m_n_q[i]  <= n_n_q[i];
        m_v_q[i]  <= n_v_q[i];
        r_n_q[i]  <= m_n_q[i];
        r_v_q[i]  <= m_v_q[i];
        q_rn_q[i] <= 62'(r_r_q * $signed(r_n_q[i]));
        q_v_q[i]  <= r_v_q[i];
        if (q_fl_q[1]) begin
          m_axis_tdata[i*32 +: 32]     <= '0;
          m_axis_tdata[(3+i)*32 +: 32] <= q_v_q[i];
        end else begin
          m_axis_tdata[i*32 +: 32]     <= 32'($signed(q_nn_q[i]));
          m_axis_tdata[(3+i)*32 +: 32] <= o_v[i];
        end
      end
      r_r_q        <= 36'(rnd24(64'(acc)));
      n_fl_q       <= {dv_side_q[DivSteps].zero, dv_side_q[DivSteps].last};
      m_fl_q       <= n_fl_q;
      r_fl_q       <= m_fl_q;
      q_fl_q       <= r_fl_q;
      q_nn_q       <= r_n_q;
      m_axis_tuser <= q_fl_q[1];
      m_axis_tlast <= q_fl_q[0];
    end
  end

endmodule
